// ----- rtl/core/mwrt_pkg.sv -----
`default_nettype none
package mwrt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned RSSI_W = 8;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned REQ_W = 3;

	localparam logic signed [RSSI_W-1:0] RSSI_ABSENT = -8'sd100;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD      = 3'd0,
		REQ_REMOVE   = 3'd1,
		REQ_CONTAINS = 3'd2,
		REQ_SET_RSSI = 3'd3,
		REQ_GET_RSSI = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan;
		logic fetch;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/core/mwrt_ctrl.sv -----
`default_nettype none
module mwrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire mwrt_pkg::status_t status,
	output mwrt_pkg::cmd_t         cmd
);
	import mwrt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/mwrt_dp.sv -----
`default_nettype none
module mwrt_dp #(
	parameter int unsigned TABLE_ENTRIES = mwrt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mwrt_pkg::cmd_t                       cmd,
	output mwrt_pkg::status_t                         status,
	input  wire logic                                 cfg_valid,
	input  wire logic [mwrt_pkg::TIMEOUT_W-1:0]       stale_timeout_ms,
	input  wire logic [mwrt_pkg::REQ_W-1:0]           req_type,
	input  wire logic [mwrt_pkg::ADDR_W-1:0]          station_address,
	input  wire logic signed [mwrt_pkg::RSSI_W-1:0]   rssi_value,
	input  wire logic [mwrt_pkg::TIME_W-1:0]          now_ms,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      found,
	output logic signed [mwrt_pkg::RSSI_W-1:0]        rssi_out,
	output logic                                      table_full
);
	import mwrt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [ADDR_W-1:0]        addr_mem [TABLE_ENTRIES];
	logic signed [RSSI_W-1:0] rssi_mem [TABLE_ENTRIES];
	logic [TIME_W-1:0]        last_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [TIMEOUT_W-1:0]     timeout_q;
	logic [REQ_W-1:0]         req_q;
	logic [ADDR_W-1:0]        addr_q;
	logic signed [RSSI_W-1:0] rssi_in_q;
	logic [TIME_W-1:0]        now_q;

	logic [IDX_W-1:0]         idx_q;
	logic                     chk_s1;
	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [ADDR_W-1:0]        addr_s1;

	logic                     found_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     free_ok_q;
	logic [IDX_W-1:0]         free_q;

	logic signed [RSSI_W-1:0] rssi_rd_q;
	logic [TIME_W-1:0]        last_rd_q;

	logic                     out_valid_q;
	logic                     out_found_q;
	logic signed [RSSI_W-1:0] out_rssi_q;
	logic                     out_full_q;

	logic [TIME_W-1:0]        age;
	logic                     fresh;
	logic                     do_add;
	logic                     do_set;
	logic                     do_remove;
	logic                     is_get;
	logic                     add_full;
	logic [IDX_W-1:0]         wr_idx;
	logic signed [RSSI_W-1:0] wr_rssi;
	logic signed [RSSI_W-1:0] lookup_rssi;

	assign age = now_q - last_rd_q;
	assign fresh = age < {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q};

	always_comb begin
		do_add = 1'b0;
		do_set = 1'b0;
		do_remove = 1'b0;
		is_get = 1'b0;
		add_full = 1'b0;
		unique case (req_q)
			REQ_ADD: begin
				do_add = !found_q && free_ok_q;
				add_full = !found_q && !free_ok_q;
			end
			REQ_REMOVE: begin
				do_remove = found_q;
			end
			REQ_SET_RSSI: begin
				do_set = found_q;
			end
			REQ_GET_RSSI: begin
				is_get = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr_idx = do_add ? free_q : slot_q;
	assign wr_rssi = do_add ? RSSI_ABSENT : rssi_in_q;
	assign lookup_rssi = (found_q && fresh) ? rssi_rd_q : RSSI_ABSENT;

	always_comb begin
		status.scan_last = (idx_q == LAST_IDX);
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign found = out_found_q;
	assign rssi_out = out_rssi_q;
	assign table_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			valid_q <= '0;
			idx_q <= '0;
			chk_s1 <= 1'b0;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= stale_timeout_ms;
			end
			chk_s1 <= cmd.scan;
			if (cmd.load_req) begin
				idx_q <= '0;
				found_q <= 1'b0;
				free_ok_q <= 1'b0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (chk_s1) begin
				if (vld_s1 && addr_s1 == addr_q) begin
					found_q <= 1'b1;
				end
				if (!vld_s1 && !free_ok_q) begin
					free_ok_q <= 1'b1;
				end
			end
			if (cmd.exec) begin
				if (do_add) begin
					valid_q[free_q] <= 1'b1;
				end else if (do_remove) begin
					valid_q[slot_q] <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_type;
			addr_q <= station_address;
			rssi_in_q <= rssi_value;
			now_q <= now_ms;
		end
		if (cmd.scan) begin
			addr_s1 <= addr_mem[idx_q];
			vld_s1 <= valid_q[idx_q];
			idx_s1 <= idx_q;
		end
		if (chk_s1) begin
			if (vld_s1 && addr_s1 == addr_q) begin
				slot_q <= idx_s1;
			end
			if (!vld_s1 && !free_ok_q) begin
				free_q <= idx_s1;
			end
		end
		if (cmd.fetch) begin
			rssi_rd_q <= rssi_mem[slot_q];
			last_rd_q <= last_mem[slot_q];
		end
		if (cmd.exec) begin
			if (do_add) begin
				addr_mem[free_q] <= addr_q;
			end
			if (do_add || do_set) begin
				rssi_mem[wr_idx] <= wr_rssi;
				last_mem[wr_idx] <= now_q;
			end
			out_found_q <= found_q;
			out_rssi_q <= is_get ? lookup_rssi : '0;
			out_full_q <= add_full;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/mac_whitelist_rssi_table.sv -----
`default_nettype none
// Channel   Direction  Handshake          Word
// request   in         in_valid/in_stall   req_type, station_address, rssi_value, now_ms
// result    out        out_valid/out_stall found, rssi_out, table_full
// config    in         cfg_valid/cfg_ready stale_timeout_ms
//
// A request is accepted in the idle state; its result word is registered on the return to
// idle, and the next request can be taken in that cycle. A result is written only once the
// output register is free. The address scan examines one table entry per cycle.
// Reset clears all valid bits and loads a timeout of 1000 ms.
// A result waits in the output register while a new request is scanned.
module mac_whitelist_rssi_table #(
	parameter int unsigned TABLE_ENTRIES = mwrt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [mwrt_pkg::TIMEOUT_W-1:0]       stale_timeout_ms,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [mwrt_pkg::REQ_W-1:0]           req_type,
	input  wire logic [mwrt_pkg::ADDR_W-1:0]          station_address,
	input  wire logic signed [mwrt_pkg::RSSI_W-1:0]   rssi_value,
	input  wire logic [mwrt_pkg::TIME_W-1:0]          now_ms,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      found,
	output logic signed [mwrt_pkg::RSSI_W-1:0]        rssi_out,
	output logic                                      table_full
);
	import mwrt_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mwrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mwrt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_valid        (cfg_valid),
		.stale_timeout_ms (stale_timeout_ms),
		.req_type         (req_type),
		.station_address  (station_address),
		.rssi_value       (rssi_value),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.rssi_out         (rssi_out),
		.table_full       (table_full)
	);

endmodule
`default_nettype wire
